### hw/rtl/ipd_pkg.sv
// shared types, constants and helpers of the packet deframer
package ipd_pkg;

  localparam int unsigned LEN_BITS_DEF = 16;
  localparam int unsigned TICK_W       = 20;
  localparam int unsigned BUF_W        = 16;
  localparam int unsigned ID_W         = 4;
  localparam int unsigned TL_W         = 16;
  localparam int unsigned CFG_DATA_W   = 20;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned MARK_LEN     = 5;
  localparam int unsigned MPOS_W       = 3;

  localparam logic [TICK_W-1:0] HDR_TIMEOUT_RST = TICK_W'(1000);
  localparam logic [TICK_W-1:0] PAY_TIMEOUT_RST = TICK_W'(3000);
  localparam logic [BUF_W-1:0]  BUF_SIZE_RST    = BUF_W'(2048);
  localparam logic [ID_W-1:0]   MAX_ID_RST      = ID_W'(4);

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_ERR  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HDR_TIMEOUT = 2'd0,
    CFG_PAY_TIMEOUT = 2'd1,
    CFG_BUF_SIZE    = 2'd2,
    CFG_MAX_ID      = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_BAD_ID      = 3'd1,
    ERR_ZERO_LEN    = 3'd2,
    ERR_HDR_TIMEOUT = 3'd3,
    ERR_PAY_TIMEOUT = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_NUM     = 2'd1,
    PH_DELIVER = 2'd2,
    PH_DROP    = 2'd3
  } phase_e;

  typedef struct packed {
    logic [TICK_W-1:0] header_timeout;
    logic [TICK_W-1:0] payload_timeout;
    logic [BUF_W-1:0]  max_payload;
    logic [ID_W-1:0]   max_link_id;
  } cfg_t;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic            kind;
    logic [7:0]      data_byte;
    logic [ID_W-1:0] link_id;
    logic            has_link_id;
    logic [TL_W-1:0] total_length;
    logic            last;
    logic [2:0]      error_code;
  } out_item_t;

  // header mark "+IPD,"
  function automatic logic [7:0] mark_char(logic [MPOS_W-1:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = CH_PLUS;
      3'd1:    c = 8'h49;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h44;
      3'd4:    c = CH_COMMA;
      default: c = CH_PLUS;
    endcase
    return c;
  endfunction

endpackage

### hw/rtl/ipd_stream_if.sv
// valid/ready stream channel carrying one payload item
interface ipd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/ipd_cfg_regs.sv
// configuration register file of the packet deframer
module ipd_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ipd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ipd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output ipd_pkg::cfg_t                       cfg_o
);
  import ipd_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_timeout  <= HDR_TIMEOUT_RST;
      cfg_q.payload_timeout <= PAY_TIMEOUT_RST;
      cfg_q.max_payload     <= BUF_SIZE_RST;
      cfg_q.max_link_id     <= MAX_ID_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_HDR_TIMEOUT: cfg_q.header_timeout  <= cfg_data_i[TICK_W-1:0];
        CFG_PAY_TIMEOUT: cfg_q.payload_timeout <= cfg_data_i[TICK_W-1:0];
        CFG_BUF_SIZE:    cfg_q.max_payload     <= cfg_data_i[BUF_W-1:0];
        CFG_MAX_ID:      cfg_q.max_link_id     <= cfg_data_i[ID_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/ipd_in_stage.sv
// input register stage of the packet deframer
module ipd_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  ipd_stream_if.sink        rx_i,
  output logic              item_valid_o,
  output ipd_pkg::in_item_t item_o,
  input  logic              item_take_i
);
  import ipd_pkg::*;

  logic     valid_q;
  in_item_t item_q;

  // refill in the same cycle the held item is consumed
  assign rx_i.ready = !valid_q || item_take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      item_q <= rx_i.payload;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### hw/rtl/ipd_parser.sv
// header parser, payload counter and result register of the packet deframer
module ipd_parser #(
  parameter int unsigned LEN_BITS = ipd_pkg::LEN_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ipd_pkg::cfg_t     cfg_i,
  input  logic              item_valid_i,
  input  ipd_pkg::in_item_t item_i,
  output logic              item_take_o,
  ipd_stream_if.source      res_o
);
  import ipd_pkg::*;

  localparam int unsigned LW = LEN_BITS;
  localparam int unsigned CW = (LW > BUF_W) ? LW : BUF_W;

  phase_e            phase_q, phase_d;
  logic [MPOS_W-1:0] mpos_q, mpos_d;
  logic [LW-1:0]     first_q, first_d;
  logic [LW-1:0]     second_q, second_d;
  logic              stopped_q, stopped_d;
  logic              comma_q, comma_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [LW-1:0]     remain_q, remain_d;
  logic [LW-1:0]     deliver_q, deliver_d;

  logic              res_valid_q;
  out_item_t         res_q;
  logic              has_res;
  out_item_t         res_item;

  logic              fire;
  logic              is_tick;
  logic [7:0]        b;
  logic              is_digit;
  logic [3:0]        digit;
  logic [TICK_W-1:0] tick_inc;
  logic              pay_expired;
  logic              hdr_expired;
  logic              bad_id;
  logic [LW-1:0]     hdr_len;
  logic [BUF_W-1:0]  cap;
  logic [LW-1:0]     capped_len;
  logic              last_byte;
  logic [MPOS_W-1:0] mpos_eff;
  logic              go_hunt;

  function automatic logic [LW-1:0] add_digit(logic [LW-1:0] v, logic [3:0] d);
    logic [LW+3:0] n;
    n = ({4'b0, v} << 3) + ({4'b0, v} << 1) + (LW + 4)'(d);
    // saturate at all ones
    if (|n[LW+3:LW]) begin
      return '1;
    end
    return n[LW-1:0];
  endfunction

  assign fire        = item_valid_i && (!res_valid_q || res_o.ready);
  assign item_take_o = fire;

  assign is_tick  = (item_i.op == OP_TICK);
  assign b        = item_i.rx_byte;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign digit    = 4'(b - CH_ZERO);
  assign tick_inc = (tick_q != '1) ? tick_q + TICK_W'(1) : tick_q;

  assign pay_expired = (tick_inc >= cfg_i.payload_timeout);
  assign hdr_expired = (tick_inc >= cfg_i.header_timeout);
  assign bad_id      = comma_q && (first_q > LW'(cfg_i.max_link_id));
  assign hdr_len     = comma_q ? second_q : first_q;
  assign cap         = (cfg_i.max_payload == '0) ? BUF_W'(1) : cfg_i.max_payload;
  assign capped_len  = (CW'(hdr_len) > CW'(cap)) ? LW'(cap) : hdr_len;
  assign last_byte   = (deliver_q <= LW'(1));
  assign mpos_eff    = (mpos_q > MPOS_W'(MARK_LEN - 1)) ? '0 : mpos_q;

  // next state
  always_comb begin
    phase_d   = phase_q;
    mpos_d    = mpos_q;
    first_d   = first_q;
    second_d  = second_q;
    stopped_d = stopped_q;
    comma_d   = comma_q;
    tick_d    = tick_q;
    remain_d  = remain_q;
    deliver_d = deliver_q;
    go_hunt   = 1'b0;

    if (is_tick) begin
      tick_d = tick_inc;
      if (phase_q == PH_DELIVER) begin
        go_hunt = pay_expired;
      end else begin
        go_hunt = hdr_expired;
      end
    end else begin
      case (phase_q)
        PH_NUM: begin
          if (b == CH_COLON) begin
            if (bad_id || (hdr_len == '0)) begin
              go_hunt = 1'b1;
            end else begin
              first_d   = comma_q ? first_q : '0;
              second_d  = hdr_len;
              remain_d  = hdr_len;
              deliver_d = capped_len;
              tick_d    = '0;
              phase_d   = PH_DELIVER;
            end
          end else if ((b == CH_COMMA) && !comma_q) begin
            comma_d   = 1'b1;
            stopped_d = 1'b0;
          end else if (is_digit && !stopped_q) begin
            if (comma_q) begin
              second_d = add_digit(second_q, digit);
            end else begin
              first_d = add_digit(first_q, digit);
            end
          end else if (!is_digit) begin
            stopped_d = 1'b1;
          end
        end
        PH_DELIVER: begin
          if (deliver_q != '0) begin
            deliver_d = deliver_q - LW'(1);
          end
          if (remain_q != '0) begin
            remain_d = remain_q - LW'(1);
          end
          if (last_byte) begin
            if (remain_q > LW'(1)) begin
              phase_d = PH_DROP;
              tick_d  = '0;
            end else begin
              go_hunt = 1'b1;
            end
          end
        end
        PH_DROP: begin
          if (remain_q != '0) begin
            remain_d = remain_q - LW'(1);
          end
          go_hunt = (remain_q <= LW'(1));
        end
        default: begin
          phase_d = PH_HUNT;
          if (b == mark_char(mpos_eff)) begin
            if (mpos_eff == MPOS_W'(MARK_LEN - 1)) begin
              phase_d   = PH_NUM;
              mpos_d    = '0;
              first_d   = '0;
              second_d  = '0;
              stopped_d = 1'b0;
              comma_d   = 1'b0;
            end else begin
              mpos_d = mpos_eff + MPOS_W'(1);
            end
          end else begin
            mpos_d = (b == CH_PLUS) ? MPOS_W'(1) : '0;
          end
        end
      endcase
    end

    if (go_hunt) begin
      phase_d   = PH_HUNT;
      mpos_d    = '0;
      first_d   = '0;
      second_d  = '0;
      stopped_d = 1'b0;
      comma_d   = 1'b0;
      tick_d    = '0;
      remain_d  = '0;
      deliver_d = '0;
    end
  end

  // result of the current item
  always_comb begin
    has_res               = 1'b0;
    res_item.kind         = KIND_ERR;
    res_item.data_byte    = '0;
    res_item.link_id      = '0;
    res_item.has_link_id  = 1'b0;
    res_item.total_length = '0;
    res_item.last         = 1'b0;
    res_item.error_code   = ERR_NONE;

    if (is_tick) begin
      if (phase_q == PH_DELIVER) begin
        if (pay_expired) begin
          has_res               = 1'b1;
          res_item.link_id      = comma_q ? first_q[ID_W-1:0] : '0;
          res_item.has_link_id  = comma_q;
          res_item.total_length = TL_W'(second_q);
          res_item.error_code   = ERR_PAY_TIMEOUT;
        end
      end else if (hdr_expired && (phase_q != PH_DROP)) begin
        has_res             = 1'b1;
        res_item.error_code = ERR_HDR_TIMEOUT;
      end
    end else begin
      case (phase_q)
        PH_NUM: begin
          if (b == CH_COLON) begin
            if (bad_id) begin
              has_res             = 1'b1;
              res_item.error_code = ERR_BAD_ID;
            end else if (hdr_len == '0) begin
              has_res              = 1'b1;
              res_item.link_id     = comma_q ? first_q[ID_W-1:0] : '0;
              res_item.has_link_id = comma_q;
              res_item.error_code  = ERR_ZERO_LEN;
            end
          end
        end
        PH_DELIVER: begin
          has_res               = 1'b1;
          res_item.kind         = KIND_DATA;
          res_item.data_byte    = b;
          res_item.link_id      = comma_q ? first_q[ID_W-1:0] : '0;
          res_item.has_link_id  = comma_q;
          res_item.total_length = TL_W'(second_q);
          res_item.last         = last_byte;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      mpos_q    <= '0;
      first_q   <= '0;
      second_q  <= '0;
      stopped_q <= 1'b0;
      comma_q   <= 1'b0;
      tick_q    <= '0;
      remain_q  <= '0;
      deliver_q <= '0;
    end else if (fire) begin
      phase_q   <= phase_d;
      mpos_q    <= mpos_d;
      first_q   <= first_d;
      second_q  <= second_d;
      stopped_q <= stopped_d;
      comma_q   <= comma_d;
      tick_q    <= tick_d;
      remain_q  <= remain_d;
      deliver_q <= deliver_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (fire) begin
      res_valid_q <= has_res;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && has_res) begin
      res_q <= res_item;
    end
  end

  assign res_o.valid   = res_valid_q;
  assign res_o.payload = res_q;

  a_deliver_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DELIVER) |-> ((deliver_q != '0) && (deliver_q <= remain_q)))
    else $error("deliver count out of range");

  a_drop_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DROP) |-> (remain_q != '0))
    else $error("drop phase with nothing left to drop");

  a_last_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !is_tick && (phase_q == PH_DELIVER) && last_byte) |=> (phase_q != PH_DELIVER))
    else $error("still delivering after last byte");

  a_mark_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mpos_q <= MPOS_W'(MARK_LEN - 1))
    else $error("header match position out of range");

  a_data_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && has_res && (res_item.kind == KIND_DATA)) |=>
      (res_valid_q && (res_q.error_code == ERR_NONE) && (res_q.data_byte == $past(b))))
    else $error("payload result malformed");

endmodule

### hw/rtl/ipd_packet_deframer.sv
// top level of the packet deframer
// Takes one transaction per cycle while the result output is not stalled: a
// received modem byte or a timer tick. It hunts for "+IPD," then reads
// "<len>:" or "<id>,<len>:", and streams out up to the configured payload limit
// of bytes per packet with the last one flagged, dropping the rest of the
// announced length. Bad link id, zero length, header timeout and payload timeout
// each give one error transaction. Each input transaction yields zero or one
// result, held first in the input register and then, after the per-byte state
// update, in the result register, which holds off the next transaction until taken.
// Write configuration only while the block is idle.
module ipd_packet_deframer #(
  parameter int unsigned LEN_BITS = ipd_pkg::LEN_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ipd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ipd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ipd_stream_if.sink                     rx_i,
  ipd_stream_if.source                   res_o
);
  import ipd_pkg::*;

  cfg_t     cfg;
  logic     item_valid;
  in_item_t item;
  logic     item_take;

  ipd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ipd_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  ipd_parser #(
    .LEN_BITS (LEN_BITS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .res_o        (res_o)
  );

endmodule
